[rtl/core/ypl_pkg.sv]
package ypl_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int TRIG_STEPS      = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    localparam logic signed [15:0] UP_X_RESET = 16'sd0;
    localparam logic signed [15:0] UP_Y_RESET = 16'sd16384;
    localparam logic signed [15:0] UP_Z_RESET = 16'sd0;

    typedef struct packed {
        logic signed [13:0] yaw_red;
        logic               yaw_neg;
        logic signed [13:0] pitch_red;
        logic               pitch_neg;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } ypl_item_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } ypl_up_t;

    // Packed so that right_x lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] trans_z;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_x;
        logic signed [15:0] dir_z;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] upward_z;
        logic signed [15:0] upward_y;
        logic signed [15:0] upward_x;
        logic signed [15:0] right_z;
        logic signed [15:0] right_y;
        logic signed [15:0] right_x;
    } ypl_result_t;

    function automatic logic signed [25:0] atan_entry(input logic [4:0] i);
        logic signed [25:0] t;
        case (i)
            5'd0:    t = 26'sd2949120;
            5'd1:    t = 26'sd1740967;
            5'd2:    t = 26'sd919879;
            5'd3:    t = 26'sd466945;
            5'd4:    t = 26'sd234379;
            5'd5:    t = 26'sd117304;
            5'd6:    t = 26'sd58666;
            5'd7:    t = 26'sd29335;
            5'd8:    t = 26'sd14668;
            5'd9:    t = 26'sd7334;
            5'd10:   t = 26'sd3667;
            5'd11:   t = 26'sd1833;
            5'd12:   t = 26'sd917;
            5'd13:   t = 26'sd458;
            5'd14:   t = 26'sd229;
            5'd15:   t = 26'sd115;
            5'd16:   t = 26'sd57;
            5'd17:   t = 26'sd29;
            5'd18:   t = 26'sd14;
            5'd19:   t = 26'sd7;
            5'd20:   t = 26'sd4;
            5'd21:   t = 26'sd2;
            5'd22:   t = 26'sd1;
            default: t = 26'sd0;
        endcase
        return t;
    endfunction

endpackage

[rtl/core/ypl_front.sv]
module ypl_front import ypl_pkg::*; (
    input  logic [127:0] s_tdata,  // yaw_angle, pitch_angle, pos_x, pos_y, pos_z
    output ypl_item_t    item
);

    function automatic logic [14:0] reduce(input logic signed [15:0] a);
        logic signed [17:0] v;
        logic signed [17:0] m;
        logic signed [17:0] r;
        logic               neg;
        v = 18'(a);
        if (v < -18'sd23040) begin
            m = v + 18'sd46080;
        end else if (v < 18'sd0) begin
            m = v + 18'sd23040;
        end else if (v >= 18'sd23040) begin
            m = v - 18'sd23040;
        end else begin
            m = v;
        end
        neg = 1'b0;
        if (m > 18'sd5760 && m <= 18'sd17280) begin
            r   = m - 18'sd11520;
            neg = 1'b1;
        end else if (m > 18'sd17280) begin
            r = m - 18'sd23040;
        end else begin
            r = m;
        end
        return {r[13:0], neg};
    endfunction

    logic [14:0] yaw_c;
    logic [14:0] pitch_c;

    assign yaw_c   = reduce(s_tdata[15:0]);
    assign pitch_c = reduce(s_tdata[31:16]);

    always_comb begin
        item.yaw_red   = yaw_c[14:1];
        item.yaw_neg   = yaw_c[0];
        item.pitch_red = pitch_c[14:1];
        item.pitch_neg = pitch_c[0];
        item.pos_x     = s_tdata[63:32];
        item.pos_y     = s_tdata[95:64];
        item.pos_z     = s_tdata[127:96];
    end

endmodule

[rtl/core/ypl_queue.sv]
module ypl_queue import ypl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  ypl_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output ypl_item_t out_item
);

    ypl_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/ypl_back.sv]
module ypl_back import ypl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  ypl_item_t   in_item,
    input  ypl_up_t     base_up,
    output logic        out_valid,
    input  logic        out_ready,
    output ypl_result_t out_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TRIG = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_SQRT = 8'b0001_0000,
        ST_DIVI = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        J_FRONT, J_NF, J_CR1, J_NR, J_CR2, J_NU, J_CR3, J_NR2, J_CR4, J_DT0, J_DT1, J_DT2
    } job_t;

    state_t state_reg;
    job_t   job_reg;
    logic [2:0] k_reg;
    logic [5:0] sc_reg;

    logic signed [32:0] yx_reg, yy_reg, px_reg, py_reg;
    logic signed [25:0] yz_reg, pz_reg;
    logic               yneg_reg, pneg_reg;
    logic signed [27:0] cy_reg, sy_reg, cp_reg, sp_reg;

    logic signed [27:0] v_reg  [3];
    logic signed [27:0] f_reg  [3];
    logic signed [27:0] r_reg  [3];
    logic signed [27:0] u_reg  [3];
    logic signed [27:0] r2_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] tr_reg [3];

    logic signed [59:0] prod_reg;
    logic signed [60:0] acc_reg;
    logic [56:0] sq_n_reg, sq_r_reg, sq_b_reg;
    logic [27:0] root_reg;
    logic [28:0] dv_rem_reg;
    logic [24:0] dv_low_reg;
    logic [24:0] dv_q_reg;

    logic        out_valid_reg;
    ypl_result_t out_reg;

    logic signed [27:0] d_vec [3];
    logic signed [25:0] bu_vec [3];

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_vec[i] = -f_reg[i];
        end
        bu_vec[0] = {base_up.x[15:0], 10'd0};
        bu_vec[1] = {base_up.y[15:0], 10'd0};
        bu_vec[2] = {base_up.z[15:0], 10'd0};
    end

    function automatic logic [1:0] idx_plus(input logic [1:0] c, input logic two);
        logic [1:0] r;
        case (c)
            2'd0:    r = two ? 2'd2 : 2'd1;
            2'd1:    r = two ? 2'd0 : 2'd2;
            default: r = two ? 2'd1 : 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] axis_out(input logic signed [27:0] c);
        logic signed [28:0] t;
        t = (29'(c) + 29'sd512) >>> 10;
        if (t > 29'sd16384) begin
            t = 29'sd16384;
        end else if (t < -29'sd16384) begin
            t = -29'sd16384;
        end
        return t[15:0];
    endfunction

    function automatic logic signed [31:0] trans_out(input logic signed [60:0] a);
        logic signed [61:0] t;
        t = -((62'(a) + 62'sd8388608) >>> 24);
        if (t > 62'sd2147483647) begin
            t = 62'sd2147483647;
        end else if (t < -62'sd2147483648) begin
            t = -62'sd2147483648;
        end
        return t[31:0];
    endfunction

    logic [1:0]  kk, ia, ib;
    logic        sub;
    logic signed [27:0] mul_a;
    logic signed [31:0] mul_b;
    logic        is_cross;
    logic [1:0]  dt_idx;

    assign kk = k_reg[1:0];
    assign ia = idx_plus(k_reg[2:1], k_reg[0]);
    assign ib = idx_plus(k_reg[2:1], !k_reg[0]);
    assign is_cross = (job_reg == J_CR1) || (job_reg == J_CR2) ||
                      (job_reg == J_CR3) || (job_reg == J_CR4);
    assign dt_idx = (job_reg == J_DT0) ? 2'd0 : ((job_reg == J_DT1) ? 2'd1 : 2'd2);

    always_comb begin
        sub   = is_cross && k_reg[0];
        mul_a = v_reg[kk];
        mul_b = 32'(v_reg[kk]);
        case (job_reg)
            J_FRONT: begin
                mul_a = k_reg[0] ? sy_reg : cy_reg;
                mul_b = 32'(cp_reg);
            end
            J_CR1: begin
                mul_a = f_reg[ia];
                mul_b = 32'(bu_vec[ib]);
            end
            J_CR2: begin
                mul_a = r_reg[ia];
                mul_b = 32'(f_reg[ib]);
            end
            J_CR3: begin
                mul_a = u_reg[ia];
                mul_b = 32'(d_vec[ib]);
            end
            J_CR4: begin
                mul_a = d_vec[ia];
                mul_b = 32'(r2_reg[ib]);
            end
            J_DT0: begin
                mul_a = r2_reg[kk];
                mul_b = pos_reg[kk];
            end
            J_DT1: begin
                mul_a = v_reg[kk];
                mul_b = pos_reg[kk];
            end
            J_DT2: begin
                mul_a = d_vec[kk];
                mul_b = pos_reg[kk];
            end
            default: begin
                mul_a = v_reg[kk];
                mul_b = 32'(v_reg[kk]);
            end
        endcase
    end

    logic signed [60:0] acc_sum;
    logic signed [60:0] acc_rnd;
    logic signed [27:0] rs24;

    assign acc_sum = sub ? (acc_reg - 61'(prod_reg)) : (acc_reg + 61'(prod_reg));
    assign acc_rnd = acc_sum + 61'sd8388608;
    assign rs24    = 28'(acc_rnd >>> 24);

    logic signed [32:0] yx_n, yy_n, px_n, py_n;
    logic signed [25:0] yz_n, pz_n;
    logic signed [32:0] yx_f, yy_f, px_f, py_f;
    logic signed [25:0] at;

    always_comb begin
        at = atan_entry(sc_reg[4:0]);
        if (yz_reg >= 26'sd0) begin
            yx_n = yx_reg - (yy_reg >>> sc_reg[4:0]);
            yy_n = yy_reg + (yx_reg >>> sc_reg[4:0]);
            yz_n = yz_reg - at;
        end else begin
            yx_n = yx_reg + (yy_reg >>> sc_reg[4:0]);
            yy_n = yy_reg - (yx_reg >>> sc_reg[4:0]);
            yz_n = yz_reg + at;
        end
        if (pz_reg >= 26'sd0) begin
            px_n = px_reg - (py_reg >>> sc_reg[4:0]);
            py_n = py_reg + (px_reg >>> sc_reg[4:0]);
            pz_n = pz_reg - at;
        end else begin
            px_n = px_reg + (py_reg >>> sc_reg[4:0]);
            py_n = py_reg - (px_reg >>> sc_reg[4:0]);
            pz_n = pz_reg + at;
        end
        yx_f = ((yneg_reg ? -yx_n : yx_n) + 33'sd32) >>> 6;
        yy_f = ((yneg_reg ? -yy_n : yy_n) + 33'sd32) >>> 6;
        px_f = ((pneg_reg ? -px_n : px_n) + 33'sd32) >>> 6;
        py_f = ((pneg_reg ? -py_n : py_n) + 33'sd32) >>> 6;
    end

    logic [56:0] sq_sum;
    logic        sq_ge;
    logic [56:0] sq_r_n;

    assign sq_sum = sq_r_reg + sq_b_reg;
    assign sq_ge  = (sq_n_reg >= sq_sum);
    assign sq_r_n = sq_ge ? ((sq_r_reg >> 1) + sq_b_reg) : (sq_r_reg >> 1);

    logic [27:0] dv_m;
    logic [51:0] dv_n;
    logic [28:0] dv_t;
    logic        dv_ge;
    logic [24:0] dv_q_n;
    logic signed [27:0] nrm_c;

    always_comb begin
        dv_m   = v_reg[kk][27] ? 28'(-v_reg[kk]) : 28'(v_reg[kk]);
        dv_n   = {dv_m, 24'd0} + 52'(root_reg >> 1);
        dv_t   = {dv_rem_reg[27:0], dv_low_reg[24]};
        dv_ge  = (dv_t >= {1'b0, root_reg});
        dv_q_n = {dv_q_reg[23:0], dv_ge};
        if (dv_q_n > 25'h100_0000) begin
            nrm_c = 28'sh100_0000;
        end else begin
            nrm_c = 28'(dv_q_n);
        end
        if (root_reg == 28'd0) begin
            nrm_c = 28'sd0;
        end else if (v_reg[kk][27]) begin
            nrm_c = -nrm_c;
        end
    end

    logic last_prod;
    logic out_load;

    always_comb begin
        case (job_reg)
            J_FRONT: last_prod = (k_reg == 3'd1);
            J_CR1, J_CR2, J_CR3, J_CR4: last_prod = (k_reg == 3'd5);
            default: last_prod = (k_reg == 3'd2);
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    if (sc_reg == 6'(TRIG_STEPS - 1)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (last_prod) begin
                        case (job_reg)
                            J_NF, J_NR, J_NU, J_NR2: state_reg <= ST_SQRT;
                            J_DT2:                   state_reg <= ST_DONE;
                            default:                 state_reg <= ST_MUL;
                        endcase
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_SQRT: begin
                    if (sc_reg == 6'd27) begin
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (sc_reg == 6'd24) begin
                        state_reg <= (k_reg == 3'd2) ? ST_MUL : ST_DIVI;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.right_x  <= axis_out(r2_reg[0]);
            out_reg.right_y  <= axis_out(r2_reg[1]);
            out_reg.right_z  <= axis_out(r2_reg[2]);
            out_reg.upward_x <= axis_out(v_reg[0]);
            out_reg.upward_y <= axis_out(v_reg[1]);
            out_reg.upward_z <= axis_out(v_reg[2]);
            out_reg.dir_x    <= axis_out(d_vec[0]);
            out_reg.dir_y    <= axis_out(d_vec[1]);
            out_reg.dir_z    <= axis_out(d_vec[2]);
            out_reg.trans_x  <= tr_reg[0];
            out_reg.trans_y  <= tr_reg[1];
            out_reg.trans_z  <= tr_reg[2];
        end
        case (state_reg)
            ST_IDLE: begin
                yx_reg     <= 33'sd652032874;
                yy_reg     <= 33'sd0;
                yz_reg     <= 26'(in_item.yaw_red) <<< 10;
                yneg_reg   <= in_item.yaw_neg;
                px_reg     <= 33'sd652032874;
                py_reg     <= 33'sd0;
                pz_reg     <= 26'(in_item.pitch_red) <<< 10;
                pneg_reg   <= in_item.pitch_neg;
                pos_reg[0] <= in_item.pos_x;
                pos_reg[1] <= in_item.pos_y;
                pos_reg[2] <= in_item.pos_z;
                sc_reg     <= 6'd0;
            end
            ST_TRIG: begin
                yx_reg <= yx_n;
                yy_reg <= yy_n;
                yz_reg <= yz_n;
                px_reg <= px_n;
                py_reg <= py_n;
                pz_reg <= pz_n;
                sc_reg <= sc_reg + 6'd1;
                cy_reg <= 28'(yx_f);
                sy_reg <= 28'(yy_f);
                cp_reg <= 28'(px_f);
                sp_reg <= 28'(py_f);
                job_reg <= J_FRONT;
                k_reg   <= 3'd0;
                acc_reg <= 61'sd0;
            end
            ST_MUL: begin
                prod_reg <= mul_a * mul_b;
            end
            ST_ACC: begin
                acc_reg <= acc_sum;
                k_reg   <= k_reg + 3'd1;
                case (job_reg)
                    J_FRONT: begin
                        acc_reg <= 61'sd0;
                        if (k_reg[0]) begin
                            v_reg[2] <= rs24;
                            v_reg[1] <= sp_reg;
                        end else begin
                            v_reg[0] <= rs24;
                        end
                    end
                    J_CR1, J_CR2, J_CR3, J_CR4: begin
                        if (k_reg[0]) begin
                            v_reg[k_reg[2:1]] <= rs24;
                            acc_reg <= 61'sd0;
                        end
                    end
                    J_DT0, J_DT1, J_DT2: begin
                        if (last_prod) begin
                            tr_reg[dt_idx] <= trans_out(acc_sum);
                            acc_reg <= 61'sd0;
                        end
                    end
                    default: begin
                        sq_n_reg <= 57'(acc_sum);
                        sq_r_reg <= 57'd0;
                        sq_b_reg <= 57'd1 << 54;
                        sc_reg   <= 6'd0;
                    end
                endcase
                if (last_prod) begin
                    k_reg <= 3'd0;
                    case (job_reg)
                        J_FRONT: job_reg <= J_NF;
                        J_CR1:   job_reg <= J_NR;
                        J_CR2:   job_reg <= J_NU;
                        J_CR3:   job_reg <= J_NR2;
                        J_CR4:   job_reg <= J_DT0;
                        J_DT0:   job_reg <= J_DT1;
                        J_DT1:   job_reg <= J_DT2;
                        default: job_reg <= job_reg;
                    endcase
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    sq_n_reg <= sq_n_reg - sq_sum;
                end
                sq_r_reg <= sq_r_n;
                sq_b_reg <= sq_b_reg >> 2;
                sc_reg   <= sc_reg + 6'd1;
                root_reg <= sq_r_n[27:0];
            end
            ST_DIVI: begin
                dv_rem_reg <= {2'd0, dv_n[51:25]};
                dv_low_reg <= dv_n[24:0];
                dv_q_reg   <= 25'd0;
                sc_reg     <= 6'd0;
            end
            ST_DIV: begin
                dv_rem_reg <= dv_ge ? (dv_t - {1'b0, root_reg}) : dv_t;
                dv_low_reg <= {dv_low_reg[23:0], 1'b0};
                dv_q_reg   <= dv_q_n;
                sc_reg     <= sc_reg + 6'd1;
                if (sc_reg == 6'd24) begin
                    case (job_reg)
                        J_NF:    f_reg[kk]  <= nrm_c;
                        J_NR:    r_reg[kk]  <= nrm_c;
                        J_NU:    u_reg[kk]  <= nrm_c;
                        default: r2_reg[kk] <= nrm_c;
                    endcase
                    k_reg <= k_reg + 3'd1;
                    if (k_reg == 3'd2) begin
                        k_reg   <= 3'd0;
                        acc_reg <= 61'sd0;
                        case (job_reg)
                            J_NF:    job_reg <= J_CR1;
                            J_NR:    job_reg <= J_CR2;
                            J_NU:    job_reg <= J_CR3;
                            default: job_reg <= J_CR4;
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/yaw_pitch_look_at_matrix.sv]
// Yaw/pitch look-at view matrix.
// Input stream s_*: one item per camera (yaw, pitch in Q10.6 degrees and a
// Q16.16 position). Output stream m_*: one item per input item carrying the
// right, up and reverse-direction rows in Q1.14 and the three Q16.16
// translations, in input order.
// A front stage reduces both angles and pushes the item into a two-entry
// queue; the back sequencer runs both CORDICs side by side, then shares one
// 28x32 multiplier, a bit-serial square root and a bit-serial divider over
// four normalizations, four cross products and three dot products.
// Per item the back runs 16 CORDIC iterations, a multiply and an
// accumulate state per product, a 28-step square root per normalization and
// a divide per component (four normalizations of three components each).
// The back works on one item at a time and takes the next only from idle.
// The input side takes up to two items while the back is busy; a finished
// result waits in the output register while the next item is computed, and
// the back holds only at its final step while m_tready stays low.
// Reset clears the queue and the output valid and loads the world up vector
// (0, 1, 0). Configuration registers at byte addresses 0, 4, 8 (up x, y, z).
module yaw_pitch_look_at_matrix import ypl_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // yaw_angle, pitch_angle, pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  logic         m_tready,
    // right_x/y/z, upward_x/y/z, dir_x/y/z (16 each), trans_x/y/z (32 each)
    output logic [239:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic signed [15:0] up_x_reg, up_y_reg, up_z_reg;
    logic               cfg_wr;
    ypl_up_t            base_up;
    ypl_item_t          front_item;
    ypl_item_t          q_item;
    logic               q_valid, q_ready;
    ypl_result_t        res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_x_reg <= UP_X_RESET;
            up_y_reg <= UP_Y_RESET;
            up_z_reg <= UP_Z_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_UP_X: up_x_reg <= pwdata[15:0];
                REG_UP_Y: up_y_reg <= pwdata[15:0];
                REG_UP_Z: up_z_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_UP_X: prdata = 32'(up_x_reg);
            REG_UP_Y: prdata = 32'(up_y_reg);
            REG_UP_Z: prdata = 32'(up_z_reg);
            default:  prdata = 32'd0;
        endcase
    end

    assign base_up.x = up_x_reg;
    assign base_up.y = up_y_reg;
    assign base_up.z = up_z_reg;

    ypl_front u_front (
        .s_tdata (s_tdata),
        .item    (front_item)
    );

    ypl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ypl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .base_up   (base_up),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = res;

endmodule

[rtl/core/ypl_checker.sv]
module ypl_props import ypl_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [3:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_UP_X) ##1
        (paddr[3:2] == REG_UP_X && !(psel && penable && pwrite))
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("up x readback mismatch");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[111:96]) <= 16'sd16384) &&
                     ($signed(m_tdata[111:96]) >= -16'sd16384) &&
                     ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                     ($signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("axis component out of range");

endmodule

bind yaw_pitch_look_at_matrix ypl_props u_chk (.*);
